FILE: hw/rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse unit.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int ELEM_W   = 32;              // element width
  localparam int FRAC_DEF = 24;              // default fraction bits
  localparam int THR_W    = 31;              // threshold register width
  localparam logic [THR_W-1:0] THR_RESET = 31'd17;

  localparam int DW = 3 * ELEM_W + 3;        // determinant width
  localparam int CW = 4 * ELEM_W + 3;        // divider working width
  localparam int NE = 9;                     // elements per matrix

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic                     singular;
  } out_t;

  // one divider lane's beat
  typedef struct packed {
    logic              vld;
    logic              sing;
    logic              neg;
    logic [CW-1:0]     num;
    logic [DW-1:0]     den;
    logic [ELEM_W-1:0] pass;
  } lane_t;

  // row-major element k of a matrix beat
  function automatic logic [ELEM_W-1:0] elem_of(in_t x, int k);
    logic [NE*ELEM_W-1:0] flat;
    flat = x;
    return flat[(NE-1-k)*ELEM_W +: ELEM_W];
  endfunction

endpackage

FILE: hw/rtl/m3i_det.sv
// ----------------------------------------------------------------------------
// m3i_det
// Cofactors, determinant and threshold test; feeds nine divider lanes.
// ----------------------------------------------------------------------------
module m3i_det #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  m3i_pkg::in_t                    in_data,
  input  logic [m3i_pkg::THR_W-1:0]       thr,
  output m3i_pkg::lane_t [m3i_pkg::NE-1:0] lane_o
);
  import m3i_pkg::*;

  localparam int E   = ELEM_W;
  localparam int PW  = 2 * E;
  localparam int CFW = 2 * E + 1;
  localparam int TW  = 3 * E + 1;

  logic [5:0] v_r;

  logic signed [E-1:0]   a      [NE];
  logic signed [E-1:0]   a2     [NE];
  in_t                   m_r    [5];
  logic signed [PW-1:0]  pa_r   [NE];
  logic signed [PW-1:0]  pb_r   [NE];
  logic signed [CFW-1:0] c2_r   [NE];
  logic signed [CFW-1:0] c3_r   [NE];
  logic signed [CFW-1:0] pl_r   [3];
  logic signed [CFW-1:0] ph_r   [3];
  logic signed [TW-1:0]  t4_r   [3];
  logic [PW-1:0]         cmag4_r[NE];
  logic [PW-1:0]         cmag5_r[NE];
  logic                  cneg4_r[NE];
  logic                  cneg5_r[NE];
  logic signed [DW-1:0]  det5_r;

  logic                  dneg;
  logic [DW-1:0]         dmag;
  logic                  sing;
  lane_t [NE-1:0]        lane_nxt;
  lane_t [NE-1:0]        lane_r;

  for (genvar k = 0; k < NE; k++) begin : g_unpack
    assign a[k]  = elem_of(in_data, k);
    assign a2[k] = elem_of(m_r[1], k);
  end

  // stage 1: the eighteen 2x2 minor products
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int I1 = (gi + 1) % 3;
      localparam int I2 = (gi + 2) % 3;
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      always_ff @(posedge clk) begin
        pa_r[gi*3+gj] <= PW'(a[I1*3+J1]) * PW'(a[I2*3+J2]);
        pb_r[gi*3+gj] <= PW'(a[I1*3+J2]) * PW'(a[I2*3+J1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    m_r[0] <= in_data;
    for (int s = 1; s < 5; s++) begin
      m_r[s] <= m_r[s-1];
    end
    for (int k = 0; k < NE; k++) begin
      // stage 2: cofactors
      c2_r[k]    <= CFW'(pa_r[k]) - CFW'(pb_r[k]);
      // stage 3: keep for magnitude
      c3_r[k]    <= c2_r[k];
      // stage 4: cofactor magnitude and sign
      cneg4_r[k] <= c3_r[k][CFW-1];
      cmag4_r[k] <= c3_r[k][CFW-1] ? PW'(-c3_r[k]) : PW'(c3_r[k]);
      cneg5_r[k] <= cneg4_r[k];
      cmag5_r[k] <= cmag4_r[k];
    end
    for (int j = 0; j < 3; j++) begin
      // stage 3: first-row products split into low and high halves
      pl_r[j] <= CFW'(a2[j]) * CFW'($signed({1'b0, c2_r[j][E-1:0]}));
      ph_r[j] <= CFW'(a2[j]) * CFW'($signed(c2_r[j][CFW-1:E]));
      // stage 4: recombine
      t4_r[j] <= (TW'(ph_r[j]) <<< E) + TW'(pl_r[j]);
    end
    // stage 5: determinant
    det5_r <= DW'(t4_r[0]) + DW'(t4_r[1]) + DW'(t4_r[2]);
    lane_r <= lane_nxt;
  end

  // stage 6: threshold test and lane setup (transposed cofactors)
  always_comb begin
    dneg = det5_r[DW-1];
    dmag = dneg ? DW'(-det5_r) : DW'(det5_r);
    sing = !(CW'(dmag) > (CW'(thr) << (2 * FRAC_BITS)));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lane_nxt[i*3+j].vld  = v_r[4] & rst_n;
        lane_nxt[i*3+j].sing = sing;
        lane_nxt[i*3+j].neg  = cneg5_r[j*3+i] ^ dneg;
        lane_nxt[i*3+j].num  = CW'(cmag5_r[j*3+i]) << (2 * FRAC_BITS);
        lane_nxt[i*3+j].den  = dmag;
        lane_nxt[i*3+j].pass = elem_of(m_r[4], i*3+j);
      end
    end
  end

  assign lane_o = lane_r;

endmodule

FILE: hw/rtl/m3i_div.sv
// ----------------------------------------------------------------------------
// m3i_div
// One divider lane: restoring division, one quotient bit per stage,
// then saturation and the singular bypass.
// ----------------------------------------------------------------------------
module m3i_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  m3i_pkg::lane_t               li,
  output logic                         o_vld,
  output logic                         o_sing,
  output logic [m3i_pkg::ELEM_W-1:0]   o_elem
);
  import m3i_pkg::*;

  localparam int E  = ELEM_W;
  localparam int NS = E + 1;   // quotient bits E..0, bit E flags overflow

  logic          vld_r  [NS];
  logic          sing_r [NS];
  logic          neg_r  [NS];
  logic [CW-1:0] rem_r  [NS];
  logic [E:0]    q_r    [NS];
  logic [DW-1:0] den_r  [NS];
  logic [E-1:0]  pass_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = E - s;
    logic          vld_i, sing_i, neg_i, ge;
    logic [CW-1:0] rem_i, dsh;
    logic [E:0]    q_i;
    logic [DW-1:0] den_i;
    logic [E-1:0]  pass_i;

    if (s == 0) begin : g_first
      assign vld_i  = li.vld;
      assign sing_i = li.sing;
      assign neg_i  = li.neg;
      assign rem_i  = li.num;
      assign q_i    = '0;
      assign den_i  = li.den;
      assign pass_i = li.pass;
    end else begin : g_next
      assign vld_i  = vld_r[s-1];
      assign sing_i = sing_r[s-1];
      assign neg_i  = neg_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign q_i    = q_r[s-1];
      assign den_i  = den_r[s-1];
      assign pass_i = pass_r[s-1];
    end

    assign dsh = CW'(den_i) << K;
    assign ge  = rem_i >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      sing_r[s] <= sing_i;
      neg_r[s]  <= neg_i;
      rem_r[s]  <= ge ? rem_i - dsh : rem_i;
      q_r[s]    <= q_i | ((E+1)'(ge) << K);
      den_r[s]  <= den_i;
      pass_r[s] <= pass_i;
    end
  end

  logic [E:0]   lim, mag;
  logic [E-1:0] res;
  logic         vout_r, sout_r;
  logic [E-1:0] eout_r;

  always_comb begin
    lim = neg_r[NS-1] ? ((E+1)'(1) << (E-1)) : (((E+1)'(1) << (E-1)) - 1'b1);
    mag = {1'b0, q_r[NS-1][E-1:0]};
    if (q_r[NS-1][E] || mag > lim) begin
      mag = lim;
    end
    res = neg_r[NS-1] ? E'(-mag) : E'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    sout_r <= sing_r[NS-1];
    eout_r <= sing_r[NS-1] ? pass_r[NS-1] : res;
  end

  assign o_vld  = vout_r;
  assign o_sing = sout_r;
  assign o_elem = eout_r;

endmodule

FILE: hw/rtl/matrix3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// Pipelined inverse of a 3x3 signed fixed-point matrix (adjugate method).
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with a matrix on in_data. busy is always low,
//   so a beat is taken at every edge where start is high, one per cycle.
//   Result beat: out_valid is high for one cycle with out_data. Results
//   come out in input order at a sustained rate of one matrix per cycle.
//   The divider lanes work one quotient bit per stage plus an overflow
//   stage, behind six stages of products, cofactors and determinant.
//   If |det| is not above the threshold the input matrix is returned and
//   singular is set. Inverted results are truncated toward zero and
//   saturated to the element range.
//   Configuration: cfg_we writes cfg_wdata to the determinant threshold
//   (Q.FRAC_BITS); write it only while no beat is in flight.
//   Reset: synchronous, clears all valid bits, threshold back to 17.
//   The receiver cannot stall; there is no back pressure.
// ----------------------------------------------------------------------------
module matrix3_inverse_unit #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  m3i_pkg::in_t                in_data,
  input  logic                        cfg_we,
  input  logic [m3i_pkg::THR_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  output m3i_pkg::out_t               out_data
);
  import m3i_pkg::*;

  localparam int LAT = ELEM_W + 8;

  logic [THR_W-1:0] thr_r;
  logic             in_vld;
  lane_t [NE-1:0]   lanes;
  logic             l_vld  [NE];
  logic             l_sing [NE];
  logic [ELEM_W-1:0] l_elem [NE];

  // no back pressure: the pipeline takes a beat every cycle
  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // products, cofactors, determinant, threshold test
  m3i_det #(
    .FRAC_BITS (FRAC_BITS)
  ) u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_data (in_data),
    .thr     (thr_r),
    .lane_o  (lanes)
  );

  // one divider lane per result element
  for (genvar k = 0; k < NE; k++) begin : g_lane
    m3i_div u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .li     (lanes[k]),
      .o_vld  (l_vld[k]),
      .o_sing (l_sing[k]),
      .o_elem (l_elem[k])
    );
  end

  // all lanes run in lockstep; lane 0 carries the beat's valid and flag
  assign out_valid         = l_vld[0];
  assign out_data.r00      = l_elem[0];
  assign out_data.r01      = l_elem[1];
  assign out_data.r02      = l_elem[2];
  assign out_data.r10      = l_elem[3];
  assign out_data.r11      = l_elem[4];
  assign out_data.r12      = l_elem[5];
  assign out_data.r20      = l_elem[6];
  assign out_data.r21      = l_elem[7];
  assign out_data.r22      = l_elem[8];
  assign out_data.singular = l_sing[0];

`ifndef SYNTHESIS
  // every result beat comes from a matching earlier input beat
  a_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld, LAT))
    else $error("result beat without matching input beat");

  // singular beats echo the input matrix; checked on r00, r11, r22 and r12
  a_echo : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |->
      (out_data.r00 == $past(in_data.m00, LAT)) &&
      (out_data.r11 == $past(in_data.m11, LAT)) &&
      (out_data.r22 == $past(in_data.m22, LAT)) &&
      (out_data.r12 == $past(in_data.m12, LAT)))
    else $error("singular beat does not echo input");
`endif

endmodule
